// ===== rtl/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Short forms for the concurrent checks used in the RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must never hold at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ogr_pkg.sv =====
// ============================================================================
// ogr_pkg
// Shared widths, codes and controller/datapath interface types.
// ============================================================================
package ogr_pkg;

  localparam int COORD_W    = 11;
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;
  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int DIM_W      = 11;
  localparam int ERR_W      = 15;
  localparam int S_DATA_W   = 48;
  localparam int M_DATA_W   = 8;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_START_OUT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_END_OUT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] GRID_RESET = 9'd256;

  typedef enum logic [1:0] {
    ADDR_SWEEP,
    ADDR_WALK,
    ADDR_END
  } addr_sel_t;

  typedef struct packed {
    logic      load_in;
    logic      init_walk;
    logic      step;
    logic      sweep;
    logic      we;
    addr_sel_t addr_sel;
    logic      load_occ;
    logic      load_out;
  } ogr_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             start_out;
    logic             end_out;
    logic             walk_last;
    logic             sweep_last;
  } ogr_stat_t;

endpackage

// ===== rtl/ogr_ram.sv =====
// ============================================================================
// ogr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module ogr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ogr_dpath.sv =====
// ============================================================================
// ogr_dpath
// Datapath: size registers, command latch, bounds checks, Bresenham walker,
// sweep counter, cell memory and the output word register.
// ============================================================================
module ogr_dpath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [ogr_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [ogr_pkg::CFG_W-1:0]        wr_data,
  input  logic [ogr_pkg::S_DATA_W-1:0]     s_tdata,
  input  logic [ogr_pkg::CMD_W-1:0]        s_tuser,
  input  ogr_pkg::ogr_cmd_t                cmd,
  output ogr_pkg::ogr_stat_t               stat,
  output logic [ogr_pkg::M_DATA_W-1:0]     m_tdata
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CW     = ogr_pkg::COORD_W;
  localparam int EW     = ogr_pkg::ERR_W;
  localparam int DW     = ogr_pkg::DIM_W;

  logic [ogr_pkg::CFG_W-1:0] grid_width;
  logic [ogr_pkg::CFG_W-1:0] grid_height;

  logic [ogr_pkg::CMD_W-1:0] cmd_r;
  logic signed [CW-1:0]      sx0, sy0, ex0, ey0;

  logic signed [CW-1:0]      x, y;
  logic signed [EW-1:0]      err, dx2, dy2;
  logic                      x_neg, y_neg, x_major;

  logic [ADDR_W-1:0]         sweep_cnt;
  logic                      res_occ;
  logic [ogr_pkg::STAT_W-1:0] res_status;

  logic [DW-1:0]             lim_w, lim_h;
  logic                      start_out, end_out;

  logic signed [CW:0]        ddx, ddy;
  logic [CW:0]               adx, ady;
  logic signed [EW-1:0]      adx_e, ady_e, dx2_init, dy2_init;
  logic                      x_major_init;
  logic signed [CW-1:0]      x_inc, y_inc;

  logic [ADDR_W-1:0]         waddr, raddr;
  logic                      wdata, rdata;

  function automatic logic in_range(logic signed [CW-1:0] c, logic [DW-1:0] lim);
    return !c[CW-1] && (DW'($unsigned(c)) < lim);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic signed [CW-1:0] cx,
                                                  logic signed [CW-1:0] cy);
    return ADDR_W'(cy[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cx[COL_W-1:0]);
  endfunction

  // Size registers above the parameter act as the parameter.
  assign lim_w = (DW'(grid_width) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(grid_width);
  assign lim_h = (DW'(grid_height) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(grid_height);

  assign start_out = !(in_range(sx0, lim_w) && in_range(sy0, lim_h));
  assign end_out   = !(in_range(ex0, lim_w) && in_range(ey0, lim_h));

  assign ddx   = {ex0[CW-1], ex0} - {sx0[CW-1], sx0};
  assign ddy   = {ey0[CW-1], ey0} - {sy0[CW-1], sy0};
  assign adx   = ddx[CW] ? $unsigned(-ddx) : $unsigned(ddx);
  assign ady   = ddy[CW] ? $unsigned(-ddy) : $unsigned(ddy);
  assign adx_e = $signed(EW'(adx));
  assign ady_e = $signed(EW'(ady));
  assign dx2_init = adx_e <<< 1;
  assign dy2_init = ady_e <<< 1;
  assign x_major_init = dx2_init > dy2_init;

  assign x_inc = x_neg ? '1 : CW'(1);
  assign y_inc = y_neg ? '1 : CW'(1);

  always_comb begin
    case (cmd_r)
      ogr_pkg::CMD_DRAW: begin
        res_status = start_out ? ogr_pkg::STAT_START_OUT :
                     end_out   ? ogr_pkg::STAT_END_OUT : ogr_pkg::STAT_OK;
      end
      ogr_pkg::CMD_READ: begin
        res_status = start_out ? ogr_pkg::STAT_START_OUT : ogr_pkg::STAT_OK;
      end
      default: begin
        res_status = ogr_pkg::STAT_OK;
      end
    endcase
  end

  always_comb begin
    case (cmd.addr_sel)
      ogr_pkg::ADDR_SWEEP: waddr = sweep_cnt;
      ogr_pkg::ADDR_WALK:  waddr = cell_addr(x, y);
      ogr_pkg::ADDR_END:   waddr = cell_addr(ex0, ey0);
      default:             waddr = sweep_cnt;
    endcase
  end

  assign wdata = (cmd.addr_sel != ogr_pkg::ADDR_SWEEP);
  assign raddr = cell_addr(sx0, sy0);

  assign stat.command    = cmd_r;
  assign stat.start_out  = start_out;
  assign stat.end_out    = end_out;
  assign stat.walk_last  = x_major ? (x == ex0) : (y == ey0);
  assign stat.sweep_last = (sweep_cnt == ADDR_W'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= ogr_pkg::GRID_RESET;
      grid_height <= ogr_pkg::GRID_RESET;
      sweep_cnt   <= '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          ogr_pkg::REG_GRID_WIDTH:  grid_width  <= wr_data;
          ogr_pkg::REG_GRID_HEIGHT: grid_height <= wr_data;
          default: ;
        endcase
      end
      if (cmd.sweep) begin
        sweep_cnt <= stat.sweep_last ? '0 : sweep_cnt + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r   <= s_tuser;
      sx0     <= s_tdata[CW-1:0];
      sy0     <= s_tdata[2*CW-1:CW];
      ex0     <= s_tdata[3*CW-1:2*CW];
      ey0     <= s_tdata[4*CW-1:3*CW];
      res_occ <= 1'b0;
    end
    if (cmd.load_occ) begin
      res_occ <= rdata;
    end
    if (cmd.init_walk) begin
      x       <= sx0;
      y       <= sy0;
      x_neg   <= ddx[CW];
      y_neg   <= ddy[CW];
      dx2     <= dx2_init;
      dy2     <= dy2_init;
      x_major <= x_major_init;
      err     <= x_major_init ? (dy2_init - adx_e) : (dx2_init - ady_e);
    end else if (cmd.step) begin
      if (x_major) begin
        x <= x + x_inc;
        if (!err[EW-1]) begin
          y   <= y + y_inc;
          err <= err - dx2 + dy2;
        end else begin
          err <= err + dy2;
        end
      end else begin
        if (!err[EW-1]) begin
          x   <= x + x_inc;
          err <= err - dy2 + dx2;
        end else begin
          err <= err + dx2;
        end
        y <= y + y_inc;
      end
    end
    if (cmd.load_out) begin
      m_tdata <= ogr_pkg::M_DATA_W'({res_occ, res_status});
    end
  end

  ogr_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

// ===== rtl/ogr_ctrl.sv =====
// ============================================================================
// ogr_ctrl
// Controller: sequences clear sweeps, line walks and cell reads, and owns
// the input ready and output valid flags.
// ============================================================================
module ogr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  ogr_pkg::ogr_stat_t stat,
  output ogr_pkg::ogr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_DRAW,
    ST_END,
    ST_READ,
    ST_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd          = '0;
    cmd.addr_sel = ogr_pkg::ADDR_SWEEP;
    case (state)
      ST_INIT, ST_CLEAR: begin
        cmd.we    = 1'b1;
        cmd.sweep = 1'b1;
      end
      ST_IDLE: begin
        cmd.load_in = s_tvalid;
      end
      ST_DECODE: begin
        cmd.init_walk = (stat.command == ogr_pkg::CMD_DRAW) &&
                        !stat.start_out && !stat.end_out;
      end
      ST_DRAW: begin
        cmd.we       = 1'b1;
        cmd.step     = 1'b1;
        cmd.addr_sel = ogr_pkg::ADDR_WALK;
      end
      ST_END: begin
        cmd.we       = 1'b1;
        cmd.addr_sel = ogr_pkg::ADDR_END;
      end
      ST_READ: begin
        cmd.load_occ = 1'b1;
      end
      ST_DONE: begin
        cmd.load_out = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          if (stat.sweep_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_tvalid) state <= ST_DECODE;
        end
        ST_DECODE: begin
          case (stat.command)
            ogr_pkg::CMD_CLEAR: state <= ST_CLEAR;
            ogr_pkg::CMD_DRAW: begin
              state <= (stat.start_out || stat.end_out) ? ST_DONE : ST_DRAW;
            end
            ogr_pkg::CMD_READ: begin
              state <= stat.start_out ? ST_DONE : ST_READ;
            end
            default: state <= ST_DONE;
          endcase
        end
        ST_CLEAR: begin
          if (stat.sweep_last) state <= ST_DONE;
        end
        ST_DRAW: begin
          // The cell on the major-axis end column or row is the last step.
          if (stat.walk_last) state <= ST_END;
        end
        ST_END: begin
          state <= ST_DONE;
        end
        ST_READ: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_INIT;
      endcase
    end
  end

endmodule

// ===== rtl/occupancy_grid_line_rasterizer_top.sv =====
// ============================================================================
// occupancy_grid_line_rasterizer_top
// One-bit occupancy grid with clear, Bresenham line draw and cell read.
// ============================================================================
//
//  Channel  Signals                      Direction  Contents
//  s        s_tvalid/s_tready/s_tdata    in         command word
//           s_tuser
//  m        m_tvalid/m_tready/m_tdata    out        result word
//  cfg      wr_en/wr_index/wr_data       in         grid size registers
//
// One command is worked on at a time; the cell memory takes one write per
// cycle. A draw writes each walked cell and then the end cell, and a read
// loads one cell; a rejected or unused command only returns a result word.
// After reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells runs before
// the first word is accepted; size registers can be written during it.
// The next word is accepted while a result word waits in the output
// register; a stalled output only holds the block at the end of that item.
//
module occupancy_grid_line_rasterizer_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [ogr_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [ogr_pkg::CFG_W-1:0]     wr_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // start_x[10:0], start_y[21:11], end_x[32:22], end_y[43:33], zero pad
  input  logic [ogr_pkg::S_DATA_W-1:0]  s_tdata,
  // command[1:0]
  input  logic [ogr_pkg::CMD_W-1:0]     s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status[1:0], occupied[2], zero pad
  output logic [ogr_pkg::M_DATA_W-1:0]  m_tdata
);

`include "assert_macros.svh"

  ogr_pkg::ogr_cmd_t  cmd;
  ogr_pkg::ogr_stat_t stat;

  ogr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ogr_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .stat     (stat),
    .m_tdata  (m_tdata)
  );

  `ASSERT_NEVER(a_no_write_when_ready, clk, rst, s_tready && cmd.we, "cell write while ready")
  `ASSERT_IMPL(a_load_out_free, clk, rst, cmd.load_out, !m_tvalid || m_tready, "result overwritten")
  `ASSERT_IMPL(a_walk_inside, clk, rst, cmd.init_walk, !stat.start_out && !stat.end_out, "walk outside")
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready, "second word taken")

endmodule
